// File: src/sxc_pkg.sv
// Shared constants, types and saturation helper for the stereo crosstalk canceller.
package sxc_pkg;

	localparam int SAMPLE_BITS     = 24;
	localparam int STAGES_DEF      = 4;
	localparam int DELAY_DEPTH_DEF = 512;

	localparam int TDATA_W    = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 26;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	localparam logic [CFG_IDX_W-1:0] CFG_BYPASS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CANCEL     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHELF_K    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_B0    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_B1    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_B2    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_A     = 3'd7;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	function automatic sample_t sat_sample(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (v > hi)
			return hi[SAMPLE_BITS-1:0];
		else if (v < lo)
			return lo[SAMPLE_BITS-1:0];
		else
			return v[SAMPLE_BITS-1:0];
	endfunction

endpackage

// File: src/sxc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sxc_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

endmodule

// File: src/sxc_mul.sv
// Shared signed multiplier with a registered product.
module sxc_mul (
	input  logic                                clk,
	input  logic signed [sxc_pkg::MUL_A_W-1:0]  a,
	input  logic signed [sxc_pkg::MUL_B_W-1:0]  b,
	output logic signed [sxc_pkg::PROD_W-1:0]   prod_q
);
	import sxc_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

// File: src/stereo_crosstalk_canceller.sv
// Top level: sequencer, state registers and configuration of the crosstalk canceller.
//
// channel   | handshake                  | payload
// s_axis    | s_axis_tvalid/s_axis_tready| tdata: left_in[23:0], right_in[47:24]
// m_axis    | m_axis_tvalid/m_axis_tready| tdata: left_out[23:0], right_out[47:24]
// cfg       | cfg_valid/cfg_ready        | cfg_index (register), cfg_data
//
// A new pair is accepted only in the idle state, once the previous pair has left the
// sequencer; every product goes through the single shared multiplier, in a multiply state
// then a wait state. Bypass pairs go from acceptance straight to the output state.
// Reset clears all filter state; the delay line is not swept, a fill mark makes
// unwritten entries read as zero. A stalled m_axis holds the finished result while
// the next pair is accepted; the sequencer waits only if a second result is ready.
module stereo_crosstalk_canceller #(
	parameter int STAGES      = sxc_pkg::STAGES_DEF,
	parameter int DELAY_DEPTH = sxc_pkg::DELAY_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [sxc_pkg::TDATA_W-1:0]      s_axis_tdata,   // left_in, right_in
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [sxc_pkg::TDATA_W-1:0]      m_axis_tdata,   // left_out, right_out
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sxc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sxc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import sxc_pkg::*;

	localparam int AW  = $clog2(DELAY_DEPTH);
	localparam int SW  = (STAGES > 1) ? $clog2(STAGES) : 1;
	localparam int DLW = 13 + STAGES;
	localparam int SB  = SAMPLE_BITS;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD   = 4'd1;
	localparam logic [3:0] ST_SR_M = 4'd2;
	localparam logic [3:0] ST_SR_W = 4'd3;
	localparam logic [3:0] ST_SL_M = 4'd4;
	localparam logic [3:0] ST_SL_W = 4'd5;
	localparam logic [3:0] ST_AL_M = 4'd6;
	localparam logic [3:0] ST_AL_W = 4'd7;
	localparam logic [3:0] ST_AR_M = 4'd8;
	localparam logic [3:0] ST_AR_W = 4'd9;
	localparam logic [3:0] ST_G_M  = 4'd10;
	localparam logic [3:0] ST_G_W  = 4'd11;
	localparam logic [3:0] ST_WR   = 4'd12;
	localparam logic [3:0] ST_BQ_M = 4'd13;
	localparam logic [3:0] ST_BQ_W = 4'd14;
	localparam logic [3:0] ST_FIN  = 4'd15;

	// configuration
	logic               bypass_q;
	logic [12:0]        base_delay_q;
	logic [15:0]        cancel_q;
	logic signed [23:0] shelf_k_q;
	logic [31:0]        coef_b0_q, coef_b1_q, coef_b2_q;
	logic [63:0]        coef_a_q;

	logic [3:0]         state_q;
	logic [SW-1:0]      stage_q;
	logic [2:0]         term_q;
	logic               chan_q;
	logic [AW-1:0]      wp_q;
	logic               full_q;
	logic               rd_valid_q;
	logic               m_valid_q;

	sample_t            in_l_q, in_r_q;
	sample_t            st_l_q, st_r_q;
	logic signed [47:0] acc_l_q, acc_r_q;
	logic [16:0]        g_q;
	logic signed [63:0] bsum_q;
	sample_t            x_l_q, x_r_q;
	sample_t            xl1_q, xl2_q, yl1_q, yl2_q;
	sample_t            xr1_q, xr2_q, yr1_q, yr2_q;
	sample_t            out_l_q, out_r_q;
	logic [TDATA_W-1:0] m_data_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [63:0]        prod64;

	logic [2*SB-1:0]    ram_rdata_q;
	logic               ram_we, ram_re;
	logic [AW-1:0]      rp;
	sample_t            d_l, d_r;
	logic [16:0]        cval;
	logic [DLW-1:0]     dsh, dly;
	logic [AW-1:0]      dly_c;
	logic               s_acc, fin_load;

	logic signed [63:0] shelf_v, sum_n, y_wide;
	sample_t            y_sat;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign fin_load      = (state_q == ST_FIN) && (!m_valid_q || m_axis_tready);

	assign cval = (cancel_q > 16'd32768) ? 17'd32768 : {1'b0, cancel_q};

	// stage delay and read address
	always_comb begin
		dsh = DLW'(base_delay_q) << stage_q;
		dly = dsh >> 4;
		if (dly > DLW'(DELAY_DEPTH - 1))
			dly_c = AW'(DELAY_DEPTH - 1);
		else if (dly == '0)
			dly_c = AW'(1);
		else
			dly_c = dly[AW-1:0];
		if (wp_q >= dly_c)
			rp = wp_q - dly_c;
		else
			rp = AW'({1'b0, wp_q} + (AW+1)'(DELAY_DEPTH) - {1'b0, dly_c});
	end

	assign ram_re = (state_q == ST_RD);
	assign ram_we = (state_q == ST_WR);
	assign d_l = rd_valid_q ? ram_rdata_q[SB-1:0]    : '0;
	assign d_r = rd_valid_q ? ram_rdata_q[2*SB-1:SB] : '0;

	sxc_ram #(
		.WIDTH(2 * SB),
		.DEPTH(DELAY_DEPTH)
	) u_dline (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (wp_q),
		.wdata  ({in_r_q, in_l_q}),
		.re     (ram_re),
		.raddr  (rp),
		.rdata_q(ram_rdata_q)
	);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SR_M: begin
				mul_a = MUL_A_W'(shelf_k_q);
				mul_b = MUL_B_W'(st_r_q) - MUL_B_W'(d_r);
			end
			ST_SL_M: begin
				mul_a = MUL_A_W'(shelf_k_q);
				mul_b = MUL_B_W'(st_l_q) - MUL_B_W'(d_l);
			end
			ST_AL_M: begin
				mul_a = MUL_A_W'(g_q);
				mul_b = MUL_B_W'(st_r_q);
			end
			ST_AR_M: begin
				mul_a = MUL_A_W'(g_q);
				mul_b = MUL_B_W'(st_l_q);
			end
			ST_G_M: begin
				mul_a = MUL_A_W'(g_q);
				mul_b = MUL_B_W'(cval);
			end
			ST_BQ_M: begin
				case (term_q)
					3'd0: begin
						mul_a = MUL_A_W'(signed'(coef_b0_q));
						mul_b = MUL_B_W'(chan_q ? x_r_q : x_l_q);
					end
					3'd1: begin
						mul_a = MUL_A_W'(signed'(coef_b1_q));
						mul_b = MUL_B_W'(chan_q ? xr1_q : xl1_q);
					end
					3'd2: begin
						mul_a = MUL_A_W'(signed'(coef_b2_q));
						mul_b = MUL_B_W'(chan_q ? xr2_q : xl2_q);
					end
					3'd3: begin
						mul_a = -MUL_A_W'(signed'(coef_a_q[31:0]));
						mul_b = MUL_B_W'(chan_q ? yr1_q : yl1_q);
					end
					3'd4: begin
						mul_a = -MUL_A_W'(signed'(coef_a_q[63:32]));
						mul_b = MUL_B_W'(chan_q ? yr2_q : yl2_q);
					end
					default: begin
						mul_a = '0;
						mul_b = '0;
					end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	sxc_mul u_mul (
		.clk   (clk),
		.a     (mul_a),
		.b     (mul_b),
		.prod_q(prod_q)
	);

	assign prod64 = 64'(prod_q);

	always_comb begin
		if (state_q == ST_SR_W)
			shelf_v = 64'(d_r) + ((prod64 + (64'sd1 <<< 19)) >>> 20);
		else
			shelf_v = 64'(d_l) + ((prod64 + (64'sd1 <<< 19)) >>> 20);
		sum_n  = bsum_q + prod64;
		y_wide = (sum_n + (64'sd1 <<< 27)) >>> 28;
		y_sat  = sat_sample(y_wide);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q     <= 1'b0;
			base_delay_q <= 13'd67;
			cancel_q     <= 16'd19661;
			shelf_k_q    <= 24'sd332923;
			coef_b0_q    <= 32'd268435456;
			coef_b1_q    <= '0;
			coef_b2_q    <= '0;
			coef_a_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BYPASS:     bypass_q     <= cfg_data[0];
				CFG_BASE_DELAY: base_delay_q <= cfg_data[12:0];
				CFG_CANCEL:     cancel_q     <= cfg_data[15:0];
				CFG_SHELF_K:    shelf_k_q    <= cfg_data[23:0];
				CFG_COEF_B0:    coef_b0_q    <= cfg_data[31:0];
				CFG_COEF_B1:    coef_b1_q    <= cfg_data[31:0];
				CFG_COEF_B2:    coef_b2_q    <= cfg_data[31:0];
				CFG_COEF_A:     coef_a_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			stage_q    <= '0;
			term_q     <= '0;
			chan_q     <= 1'b0;
			wp_q       <= '0;
			full_q     <= 1'b0;
			rd_valid_q <= 1'b0;
			m_valid_q  <= 1'b0;
			st_l_q     <= '0;
			st_r_q     <= '0;
			xl1_q      <= '0;
			xl2_q      <= '0;
			yl1_q      <= '0;
			yl2_q      <= '0;
			xr1_q      <= '0;
			xr2_q      <= '0;
			yr1_q      <= '0;
			yr2_q      <= '0;
		end else begin
			if (fin_load)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (bypass_q)
							state_q <= ST_FIN;
						else
							state_q <= ST_RD;
					end
				end
				ST_RD: begin
					rd_valid_q <= full_q || (rp < wp_q);
					state_q    <= ST_SR_M;
				end
				ST_SR_M: state_q <= ST_SR_W;
				ST_SR_W: begin
					st_r_q  <= sat_sample(shelf_v);
					state_q <= ST_SL_M;
				end
				ST_SL_M: state_q <= ST_SL_W;
				ST_SL_W: begin
					st_l_q  <= sat_sample(shelf_v);
					state_q <= ST_AL_M;
				end
				ST_AL_M: state_q <= ST_AL_W;
				ST_AL_W: state_q <= ST_AR_M;
				ST_AR_M: state_q <= ST_AR_W;
				ST_AR_W: state_q <= ST_G_M;
				ST_G_M:  state_q <= ST_G_W;
				ST_G_W: begin
					if (stage_q == SW'(STAGES - 1)) begin
						stage_q <= '0;
						state_q <= ST_WR;
					end else begin
						stage_q <= stage_q + SW'(1);
						state_q <= ST_RD;
					end
				end
				ST_WR: begin
					// advance write pointer; a wrap marks the whole line written
					if (wp_q == AW'(DELAY_DEPTH - 1)) begin
						wp_q   <= '0;
						full_q <= 1'b1;
					end else begin
						wp_q <= wp_q + AW'(1);
					end
					term_q  <= '0;
					chan_q  <= 1'b0;
					state_q <= ST_BQ_M;
				end
				ST_BQ_M: state_q <= ST_BQ_W;
				ST_BQ_W: begin
					if (term_q == 3'd4) begin
						if (chan_q) begin
							xr2_q   <= xr1_q;
							xr1_q   <= x_r_q;
							yr2_q   <= yr1_q;
							yr1_q   <= y_sat;
							state_q <= ST_FIN;
						end else begin
							xl2_q   <= xl1_q;
							xl1_q   <= x_l_q;
							yl2_q   <= yl1_q;
							yl1_q   <= y_sat;
							chan_q  <= 1'b1;
							term_q  <= '0;
							state_q <= ST_BQ_M;
						end
					end else begin
						term_q  <= term_q + 3'd1;
						state_q <= ST_BQ_M;
					end
				end
				ST_FIN: begin
					if (fin_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					in_l_q  <= s_axis_tdata[SB-1:0];
					in_r_q  <= s_axis_tdata[2*SB-1:SB];
					out_l_q <= s_axis_tdata[SB-1:0];
					out_r_q <= s_axis_tdata[2*SB-1:SB];
					acc_l_q <= {{9{s_axis_tdata[SB-1]}}, s_axis_tdata[SB-1:0], 15'd0};
					acc_r_q <= {{9{s_axis_tdata[2*SB-1]}}, s_axis_tdata[2*SB-1:SB], 15'd0};
					g_q     <= cval;
				end
			end
			ST_AL_W: acc_l_q <= acc_l_q - prod_q[47:0];
			ST_AR_W: acc_r_q <= acc_r_q - prod_q[47:0];
			ST_G_W:  g_q     <= 17'((prod64 + 64'sd16384) >>> 15);
			ST_WR: begin
				x_l_q  <= sat_sample((64'(acc_l_q) + 64'sd16384) >>> 15);
				x_r_q  <= sat_sample((64'(acc_r_q) + 64'sd16384) >>> 15);
				bsum_q <= '0;
			end
			ST_BQ_W: begin
				if (term_q == 3'd4) begin
					bsum_q <= '0;
					if (chan_q)
						out_r_q <= y_sat;
					else
						out_l_q <= y_sat;
				end else begin
					bsum_q <= sum_n;
				end
			end
			ST_FIN: begin
				if (fin_load)
					m_data_q <= {out_r_q, out_l_q};
			end
			default: ;
		endcase
	end

endmodule

// File: sim/stereo_crosstalk_canceller_tb.sv
// Self-checking testbench for the stereo crosstalk canceller: directed table, then random pairs.
`timescale 1ns / 100ps

module stereo_crosstalk_canceller_tb;
	import sxc_pkg::*;

	localparam int DEPTH       = 512;
	localparam int NSTAGE      = 4;
	localparam int LIMIT       = 2000000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [TDATA_W-1:0]    s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [TDATA_W-1:0]    m_axis_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	stereo_crosstalk_canceller u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0; #1;
		clk = 1'b1; #1;
	end

	// predictor copy of registers and filter state
	logic        p_bypass;
	logic [12:0] p_base_delay;
	logic [15:0] p_cancel;
	logic signed [23:0] p_shelf_k;
	logic signed [31:0] p_b0, p_b1, p_b2;
	logic [63:0] p_coef_a;
	longint dly_l [DEPTH];
	longint dly_r [DEPTH];
	int     wr_ptr;
	longint shelf_l, shelf_r;
	longint hist_l [4];
	longint hist_r [4];

	logic [TDATA_W-1:0] expected_pairs [$];
	int errors;
	int cycles;
	int send_idle_pct, recv_idle_pct;
	int sent;

	function automatic longint clamp24(longint v);
		if (v > 64'sd8388607) return 64'sd8388607;
		if (v < -64'sd8388608) return -64'sd8388608;
		return v;
	endfunction

	// arithmetic shift with half-up rounding
	function automatic longint round_shift(longint v, int sh);
		longint t;
		t = v + (64'sd1 <<< (sh - 1));
		return t >>> sh;
	endfunction

	function automatic longint shelf_pass(longint d, ref longint st);
		longint f;
		f = clamp24(d + round_shift(longint'(p_shelf_k) * (st - d), 28 - 8));
		st = f;
		return f;
	endfunction

	function automatic longint biquad_pass(longint x, ref longint h [4]);
		longint acc, y;
		longint a1, a2;
		a1 = longint'($signed(p_coef_a[31:0]));
		a2 = longint'($signed(p_coef_a[63:32]));
		acc = longint'(p_b0) * x + longint'(p_b1) * h[0] + longint'(p_b2) * h[1]
			- a1 * h[2] - a2 * h[3];
		y = clamp24(round_shift(acc, 28));
		h[1] = h[0]; h[0] = x; h[3] = h[2]; h[2] = y;
		return y;
	endfunction

	function automatic logic [TDATA_W-1:0] cancel_pair(logic [TDATA_W-1:0] din);
		longint in_l, in_r, g, c, acc_l, acc_r, fl, fr, d, xl, xr, yl, yr;
		int rp;
		logic [23:0] ol, orr;
		if (p_bypass) return din;
		in_l = longint'($signed(din[23:0]));
		in_r = longint'($signed(din[47:24]));
		c = (p_cancel > 16'd32768) ? 32768 : longint'(p_cancel);
		g = c;
		acc_l = in_l * 32768;
		acc_r = in_r * 32768;
		for (int s = 0; s < NSTAGE; s++) begin
			d = (longint'(p_base_delay) << s) >> 4;
			if (d > DEPTH - 1) d = DEPTH - 1;
			if (d < 1) d = 1;
			rp = (wr_ptr + DEPTH - int'(d)) % DEPTH;
			fr = shelf_pass(dly_r[rp], shelf_r);
			fl = shelf_pass(dly_l[rp], shelf_l);
			acc_l -= g * fr;
			acc_r -= g * fl;
			g = round_shift(g * c, 15);
		end
		dly_l[wr_ptr] = in_l;
		dly_r[wr_ptr] = in_r;
		wr_ptr = (wr_ptr + 1) % DEPTH;
		xl = clamp24(round_shift(acc_l, 15));
		xr = clamp24(round_shift(acc_r, 15));
		yl = biquad_pass(xl, hist_l);
		yr = biquad_pass(xr, hist_r);
		ol = yl[23:0];
		orr = yr[23:0];
		return {orr, ol};
	endfunction

	task automatic report_mismatch(string what, logic [TDATA_W-1:0] got,
			logic [TDATA_W-1:0] want);
		$display("mismatch %s: got %012h want %012h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_pairs.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata, '0);
			end else begin
				logic [TDATA_W-1:0] want;
				want = expected_pairs.pop_front();
				if (m_axis_tdata[23:0] !== want[23:0])
					report_mismatch("left_out", TDATA_W'(m_axis_tdata[23:0]),
						TDATA_W'(want[23:0]));
				if (m_axis_tdata[47:24] !== want[47:24])
					report_mismatch("right_out", TDATA_W'(m_axis_tdata[47:24]),
						TDATA_W'(want[47:24]));
			end
		end
	end

	// receiver stall
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout at cycle %0d", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_BYPASS:     p_bypass     = val[0];
			CFG_BASE_DELAY: p_base_delay = val[12:0];
			CFG_CANCEL:     p_cancel     = val[15:0];
			CFG_SHELF_K:    p_shelf_k    = val[23:0];
			CFG_COEF_B0:    p_b0         = val[31:0];
			CFG_COEF_B1:    p_b1         = val[31:0];
			CFG_COEF_B2:    p_b2         = val[31:0];
			CFG_COEF_A:     p_coef_a     = val;
			default: ;
		endcase
	endtask

	// hold the sender until the block has drained
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_pairs.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// send one pair; when check_typed is set the predictor is checked against a typed expectation
	task automatic send_pair(logic [23:0] l, logic [23:0] r, bit check_typed,
			logic [TDATA_W-1:0] typed);
		logic [TDATA_W-1:0] want;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tdata  <= {r, l};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		want = cancel_pair({r, l});
		if (check_typed && want !== typed)
			report_mismatch($sformatf("table row %0d", sent), want, typed);
		expected_pairs.insert(expected_pairs.size(), want);
		sent++;
	endtask

	typedef struct {
		logic [23:0]        left;
		logic [23:0]        right;
		bit                 typed;
		logic [TDATA_W-1:0] result;
	} stim_row_t;

	stim_row_t directed [8] = '{
		// after reset the delay lines are zero: first outputs equal inputs
		'{24'h000000, 24'h000000, 1'b1, 48'h000000_000000},
		'{24'h7FFFFF, 24'h800000, 1'b0, 48'h0},
		'{24'h800000, 24'h7FFFFF, 1'b0, 48'h0},
		'{24'h7FFFFF, 24'h7FFFFF, 1'b0, 48'h0},
		'{24'h800000, 24'h800000, 1'b0, 48'h0},
		'{24'h000001, 24'hFFFFFF, 1'b0, 48'h0},
		'{24'h555555, 24'hAAAAAA, 1'b0, 48'h0},
		'{24'hAAAAAA, 24'h555555, 1'b0, 48'h0}
	};

	task automatic random_phase(int n, int bias);
		logic [23:0] l, r;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(bias))
				0: begin l = 24'h7FFFFF; r = 24'h800000; end
				1: begin l = 24'h800000; r = 24'h7FFFFF; end
				default: begin
					l = 24'($urandom);
					r = ($urandom_range(3) == 0) ? l : 24'($urandom);
				end
			endcase
			send_pair(l, r, 1'b0, '0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_BYPASS;
		cfg_data  = '0;
		errors = 0;
		cycles = 0;
		sent = 0;
		send_idle_pct = 24;
		recv_idle_pct = 78;
		p_bypass = 1'b0; p_base_delay = 13'd67; p_cancel = 16'd19661;
		p_shelf_k = 24'sd332923; p_b0 = 32'sd268435456; p_b1 = '0; p_b2 = '0;
		p_coef_a = '0;
		foreach (dly_l[i]) begin dly_l[i] = 0; dly_r[i] = 0; end
		foreach (hist_l[i]) begin hist_l[i] = 0; hist_r[i] = 0; end
		wr_ptr = 0; shelf_l = 0; shelf_r = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_pair(directed[i].left, directed[i].right, directed[i].typed,
				directed[i].result);

		// bypass: outputs equal inputs, state frozen
		drain();
		write_reg(CFG_BYPASS, 64'd1);
		send_pair(24'h123456, 24'h800000, 1'b1, {24'h800000, 24'h123456});
		send_pair(24'h7FFFFF, 24'hFEDCBA, 1'b1, {24'hFEDCBA, 24'h7FFFFF});
		drain();
		write_reg(CFG_BYPASS, 64'd0);
		// cancel above unity, zero delay, strong shelf, loud biquad
		write_reg(CFG_CANCEL, 64'hFFFF);
		write_reg(CFG_BASE_DELAY, 64'd0);
		write_reg(CFG_SHELF_K, 64'h800000);
		write_reg(CFG_COEF_B0, 64'h7FFFFFFF);
		write_reg(CFG_COEF_B1, 64'h80000000);
		write_reg(CFG_COEF_B2, 64'h7FFFFFFF);
		write_reg(CFG_COEF_A, 64'h80000000_7FFFFFFF);
		random_phase(6, 2);
		drain();
		// longest delay and a stable filter
		write_reg(CFG_BASE_DELAY, 64'h1FFF);
		write_reg(CFG_CANCEL, 64'd32768);
		write_reg(CFG_SHELF_K, 64'h7FFFFF);
		write_reg(CFG_COEF_B0, 64'd268435456);
		write_reg(CFG_COEF_B1, 64'd0);
		write_reg(CFG_COEF_B2, 64'd0);
		write_reg(CFG_COEF_A, 64'd0);
		random_phase(450, 12);
		drain();

		send_idle_pct = 78;
		recv_idle_pct = 24;
		write_reg(CFG_BASE_DELAY, 64'd67);
		write_reg(CFG_CANCEL, 64'd0);
		write_reg(CFG_SHELF_K, 64'hFAF000);
		write_reg(CFG_COEF_B0, 64'd134217728);
		write_reg(CFG_COEF_B1, 64'hF8000000);
		write_reg(CFG_COEF_B2, 64'd67108864);
		write_reg(CFG_COEF_A, 64'h08000000_F0000000);
		random_phase(450, 12);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(CFG_BASE_DELAY, 64'd330);
		write_reg(CFG_CANCEL, 64'd19661);
		write_reg(CFG_SHELF_K, 64'd332923);
		write_reg(CFG_COEF_A, {32'd0, 32'hF8000000});
		random_phase(450, 12);
		s_axis_tvalid <= 1'b0;

		begin
			int wait_cycles;
			wait_cycles = 0;
			while (expected_pairs.size() != 0 && wait_cycles < 20000) begin
				@(posedge clk);
				wait_cycles++;
			end
			repeat (80) @(posedge clk);
		end
		if (errors == 0 && expected_pairs.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
